/* rtl/rgb2yuv_pkg.sv */
package rgb2yuv_pkg;

  // Configuration register indexes
  localparam int CfgIdxW = 1;
  localparam logic [CfgIdxW-1:0] RegImageWidth  = 1'b0;
  localparam logic [CfgIdxW-1:0] RegImageHeight = 1'b1;

  localparam int CfgDataW      = 13;
  localparam int MaxWidthDef   = 4096;
  localparam int HeightLimit   = 4096;
  localparam int RowW          = 12;
  localparam int WidthReset    = 640;
  localparam int HeightReset   = 480;
  localparam int QueueDepth    = 4;

  // BT.601 integer coefficients
  localparam logic signed [8:0] CoefYR  = 9'sd66;
  localparam logic signed [8:0] CoefYG  = 9'sd129;
  localparam logic signed [8:0] CoefYB  = 9'sd25;
  localparam logic signed [8:0] CoefCbR = -9'sd38;
  localparam logic signed [8:0] CoefCbG = -9'sd74;
  localparam logic signed [8:0] CoefCbB = 9'sd112;
  localparam logic signed [8:0] CoefCrR = 9'sd112;
  localparam logic signed [8:0] CoefCrG = -9'sd94;
  localparam logic signed [8:0] CoefCrB = -9'sd18;
  localparam logic signed [19:0] RoundHalf  = 20'sd128;
  localparam logic signed [19:0] LumaOffset = 20'sd16;
  localparam logic signed [19:0] ChromaBias = 20'sd128;

  // One classified pixel, as handed from the front end to the back end
  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [8:0] sum_r;        // pixel plus left neighbour on an odd column
    logic [8:0] sum_g;
    logic [8:0] sum_b;
    logic       pair_h;       // horizontal pair of two pixels
    logic       line_wr;      // even row: store pair sum
    logic       line_rd;      // odd row: fetch pair sum from the even row
    logic       chroma_valid;
  } rgb2yuv_item_t;

endpackage

/* rtl/rgb2yuv_queue.sv */
module rgb2yuv_queue #(
  parameter int DataW = 8,
  parameter int Depth = rgb2yuv_pkg::QueueDepth
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [DataW-1:0] push_data,
  output logic             full,
  input  logic             pop,
  output logic             not_empty,
  output logic [DataW-1:0] pop_data
);

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);

  logic [DataW-1:0] slot_r [Depth];
  logic [PtrW-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [PtrW-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [CntW-1:0]  cnt_r, cnt_nxt;
  logic             do_push, do_pop;

  assign full      = (cnt_r == CntW'(Depth));
  assign not_empty = (cnt_r != '0);
  assign pop_data  = slot_r[rd_ptr_r];
  assign do_push   = push && !full;
  assign do_pop    = pop && not_empty;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PtrW'(Depth - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PtrW'(Depth - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= push_data;
    end
  end

`ifndef ASSERT_OFF
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CntW'(Depth))
    else $error("queue count beyond depth");
  a_empty_ptrs: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r == '0) |-> (rd_ptr_r == wr_ptr_r))
    else $error("empty queue with pointers apart");
`endif

endmodule

/* rtl/rgb2yuv_front.sv */
module rgb2yuv_front #(
  parameter int MAX_WIDTH = rgb2yuv_pkg::MaxWidthDef,
  parameter int AddrW     = 11
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 cfg_we,
  input  logic [rgb2yuv_pkg::CfgIdxW-1:0]      cfg_idx,
  input  logic [rgb2yuv_pkg::CfgDataW-1:0]     cfg_wdata,
  input  logic                                 pix_accept,
  input  logic [7:0]                           pix_red,
  input  logic [7:0]                           pix_green,
  input  logic [7:0]                           pix_blue,
  output rgb2yuv_pkg::rgb2yuv_item_t           item,
  output logic [AddrW-1:0]                     item_addr
);

  localparam int ColW  = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int CmpW  = (ColW + 1 > rgb2yuv_pkg::CfgDataW) ? ColW + 1 : rgb2yuv_pkg::CfgDataW;
  localparam int RowW  = rgb2yuv_pkg::RowW;
  localparam int WEff  = (rgb2yuv_pkg::WidthReset > MAX_WIDTH) ? MAX_WIDTH
                                                               : rgb2yuv_pkg::WidthReset;
  localparam logic [ColW-1:0] WLastReset = ColW'(WEff - 1);
  localparam logic [RowW-1:0] HLastReset = RowW'(rgb2yuv_pkg::HeightReset - 1);

  logic [ColW-1:0] col_r, col_nxt;
  logic [RowW-1:0] row_r, row_nxt;
  logic [ColW-1:0] wlast_r, wlast_nxt;
  logic [RowW-1:0] hlast_r, hlast_nxt;
  logic [23:0]     left_r;
  logic [CmpW-1:0] w_cmp;
  logic [CmpW-1:0] h_cmp;
  logic            odd_col, odd_row, last_col, last_row, closes;

  assign odd_col  = col_r[0];
  assign odd_row  = row_r[0];
  assign last_col = (col_r == wlast_r);
  assign last_row = (row_r == hlast_r);
  assign closes   = odd_col || last_col;

  // Classify the pixel and build its horizontal pair sum
  always_comb begin
    item.red          = pix_red;
    item.green        = pix_green;
    item.blue         = pix_blue;
    item.pair_h       = odd_col;
    item.sum_r        = {1'b0, pix_red}   + (odd_col ? {1'b0, left_r[7:0]}   : 9'd0);
    item.sum_g        = {1'b0, pix_green} + (odd_col ? {1'b0, left_r[15:8]}  : 9'd0);
    item.sum_b        = {1'b0, pix_blue}  + (odd_col ? {1'b0, left_r[23:16]} : 9'd0);
    item.line_wr      = closes && !odd_row;
    item.line_rd      = closes && odd_row;
    item.chroma_valid = (closes && odd_row) || (closes && !odd_row && last_row);
  end

  assign item_addr = AddrW'(col_r >> 1);

  // Step raster; clamp sizes to supported range as last index; writes restart
  always_comb begin
    w_cmp     = CmpW'(cfg_wdata);
    h_cmp     = CmpW'(cfg_wdata);
    wlast_nxt = wlast_r;
    hlast_nxt = hlast_r;
    col_nxt   = col_r;
    row_nxt   = row_r;
    if (pix_accept) begin
      if (last_col) begin
        col_nxt = '0;
        row_nxt = last_row ? '0 : row_r + 1'b1;
      end else begin
        col_nxt = col_r + 1'b1;
      end
    end
    if (cfg_we) begin
      unique case (cfg_idx)
        rgb2yuv_pkg::RegImageWidth: begin
          if (w_cmp == '0) begin
            wlast_nxt = '0;
          end else if (w_cmp > CmpW'(MAX_WIDTH)) begin
            wlast_nxt = ColW'(MAX_WIDTH - 1);
          end else begin
            wlast_nxt = ColW'(w_cmp - 1'b1);
          end
        end
        rgb2yuv_pkg::RegImageHeight: begin
          if (h_cmp == '0) begin
            hlast_nxt = '0;
          end else if (h_cmp > CmpW'(rgb2yuv_pkg::HeightLimit)) begin
            hlast_nxt = RowW'(rgb2yuv_pkg::HeightLimit - 1);
          end else begin
            hlast_nxt = RowW'(h_cmp - 1'b1);
          end
        end
        default: begin
        end
      endcase
      col_nxt = '0;
      row_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r   <= '0;
      row_r   <= '0;
      wlast_r <= WLastReset;
      hlast_r <= HLastReset;
    end else begin
      col_r   <= col_nxt;
      row_r   <= row_nxt;
      wlast_r <= wlast_nxt;
      hlast_r <= hlast_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (pix_accept) begin
      left_r <= {pix_blue, pix_green, pix_red};
    end
  end

`ifndef ASSERT_OFF
  a_col_in_row: assert property (@(posedge clk) disable iff (!rst_n)
    col_r <= wlast_r)
    else $error("column beyond row end");
  a_row_in_frame: assert property (@(posedge clk) disable iff (!rst_n)
    row_r <= hlast_r)
    else $error("row beyond frame end");
`endif

endmodule

/* rtl/rgb2yuv_back.sv */
module rgb2yuv_back #(
  parameter int LineDepth = 2048,
  parameter int AddrW     = 11
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       q_valid,
  input  rgb2yuv_pkg::rgb2yuv_item_t q_item,
  input  logic [AddrW-1:0]           q_addr,
  output logic                       q_pop,
  output logic                       res_valid,
  input  logic                       res_stall,
  output logic [7:0]                 res_luma,
  output logic                       res_chroma_valid,
  output logic [7:0]                 res_cb,
  output logic [7:0]                 res_cr
);

  function automatic logic [7:0] clamp_byte(input logic signed [19:0] v);
    logic [7:0] res;
    if (v < 0) begin
      res = 8'd0;
    end else if (v > 20'sd255) begin
      res = 8'd255;
    end else begin
      res = v[7:0];
    end
    return res;
  endfunction

  logic [26:0] line_mem [LineDepth];
  logic [26:0] line_rdata_r;

  logic        adv;

  // stage 1: line store access done, pair sums held
  logic        s1_valid_r;
  rgb2yuv_pkg::rgb2yuv_item_t s1_item_r;

  // stage 2: block averages
  logic        s2_valid_r, s2_cv_r;
  logic [7:0]  s2_red_r, s2_green_r, s2_blue_r;
  logic [7:0]  s2_avg_r_r, s2_avg_g_r, s2_avg_b_r;
  logic [9:0]  tot_r, tot_g, tot_b;
  logic [1:0]  sh;

  // stage 3: products
  logic        s3_valid_r, s3_cv_r;
  logic signed [17:0] py_r [3];
  logic signed [17:0] pcb_r [3];
  logic signed [17:0] pcr_r [3];

  logic signed [19:0] y_val, cb_val, cr_val;

  logic        out_valid_r;
  logic        out_cv_r;
  logic [7:0]  out_luma_r, out_cb_r, out_cr_r;

  assign adv   = !out_valid_r || !res_stall;
  assign q_pop = adv && q_valid;

  // Line store: write even-row pair sums, read them back on the odd row
  always_ff @(posedge clk) begin
    if (q_pop && q_item.line_wr) begin
      line_mem[q_addr] <= {q_item.sum_b, q_item.sum_g, q_item.sum_r};
    end
    if (q_pop && q_item.line_rd) begin
      line_rdata_r <= line_mem[q_addr];
    end
  end

  always_comb begin
    tot_r = {1'b0, s1_item_r.sum_r} + (s1_item_r.line_rd ? {1'b0, line_rdata_r[8:0]}   : 10'd0);
    tot_g = {1'b0, s1_item_r.sum_g} + (s1_item_r.line_rd ? {1'b0, line_rdata_r[17:9]}  : 10'd0);
    tot_b = {1'b0, s1_item_r.sum_b} + (s1_item_r.line_rd ? {1'b0, line_rdata_r[26:18]} : 10'd0);
    sh    = {1'b0, s1_item_r.pair_h} + {1'b0, s1_item_r.line_rd};
  end

  always_comb begin
    y_val  = ((20'(py_r[0]) + 20'(py_r[1]) + 20'(py_r[2]) + rgb2yuv_pkg::RoundHalf) >>> 8)
             + rgb2yuv_pkg::LumaOffset;
    cb_val = ((20'(pcb_r[0]) + 20'(pcb_r[1]) + 20'(pcb_r[2]) + rgb2yuv_pkg::RoundHalf) >>> 8)
             + rgb2yuv_pkg::ChromaBias;
    cr_val = ((20'(pcr_r[0]) + 20'(pcr_r[1]) + 20'(pcr_r[2]) + rgb2yuv_pkg::RoundHalf) >>> 8)
             + rgb2yuv_pkg::ChromaBias;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      s2_valid_r  <= 1'b0;
      s3_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (adv) begin
      s1_valid_r  <= q_valid;
      s2_valid_r  <= s1_valid_r;
      s3_valid_r  <= s2_valid_r;
      out_valid_r <= s3_valid_r;
    end
  end

  // Payload advances with the pipeline; hold everything while the output stalls
  always_ff @(posedge clk) begin
    if (adv) begin
      s1_item_r  <= q_item;

      s2_cv_r    <= s1_item_r.chroma_valid;
      s2_red_r   <= s1_item_r.red;
      s2_green_r <= s1_item_r.green;
      s2_blue_r  <= s1_item_r.blue;
      s2_avg_r_r <= 8'(tot_r >> sh);
      s2_avg_g_r <= 8'(tot_g >> sh);
      s2_avg_b_r <= 8'(tot_b >> sh);

      s3_cv_r    <= s2_cv_r;
      py_r[0]    <= $signed({1'b0, s2_red_r})   * rgb2yuv_pkg::CoefYR;
      py_r[1]    <= $signed({1'b0, s2_green_r}) * rgb2yuv_pkg::CoefYG;
      py_r[2]    <= $signed({1'b0, s2_blue_r})  * rgb2yuv_pkg::CoefYB;
      pcb_r[0]   <= $signed({1'b0, s2_avg_r_r}) * rgb2yuv_pkg::CoefCbR;
      pcb_r[1]   <= $signed({1'b0, s2_avg_g_r}) * rgb2yuv_pkg::CoefCbG;
      pcb_r[2]   <= $signed({1'b0, s2_avg_b_r}) * rgb2yuv_pkg::CoefCbB;
      pcr_r[0]   <= $signed({1'b0, s2_avg_r_r}) * rgb2yuv_pkg::CoefCrR;
      pcr_r[1]   <= $signed({1'b0, s2_avg_g_r}) * rgb2yuv_pkg::CoefCrG;
      pcr_r[2]   <= $signed({1'b0, s2_avg_b_r}) * rgb2yuv_pkg::CoefCrB;

      out_cv_r   <= s3_cv_r;
      out_luma_r <= clamp_byte(y_val);
      out_cb_r   <= s3_cv_r ? clamp_byte(cb_val) : 8'd0;
      out_cr_r   <= s3_cv_r ? clamp_byte(cr_val) : 8'd0;
    end
  end

  assign res_valid        = out_valid_r;
  assign res_luma         = out_luma_r;
  assign res_chroma_valid = out_cv_r;
  assign res_cb           = out_cb_r;
  assign res_cr           = out_cr_r;

`ifndef ASSERT_OFF
  a_chroma_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_cv_r) |-> (out_cb_r == 8'd0 && out_cr_r == 8'd0))
    else $error("chroma present on a pixel that closes no block");
`endif

endmodule

/* rtl/rgb_to_yuv420_converter_top.sv */
// BT.601 RGB24 to YUV 4:2:0 converter. Feed pixels in raster order, one item per
// pixel; every item gives one result with the pixel's luma, and the item that
// closes a 2x2 block (the odd row's right pixel, or the edge pixel of a partial
// block at an odd width or height) also carries the block's averaged Cb and Cr
// with chroma_valid high; otherwise Cb and Cr read zero. Throughput is one item
// per clock while out_stall is low: the front end classifies each pixel and
// forms its horizontal pair sum, a four-entry queue decouples it from the back
// end, and the back end does one line-store access per item followed by three
// arithmetic stages. The line store holds (MAX_WIDTH+1)/2 pair sums of 27 bits
// in a single-port memory; it needs no clearing after reset, since an odd row
// only reads entries written by the even row before it. Width and height
// written through the configuration port are clamped to 1..MAX_WIDTH and
// 1..4096 and restart the frame at row 0, column 0; write them only while the
// converter is idle. cfg_ready is always high. A frame wraps to its start after
// its last pixel.
module rgb_to_yuv420_converter_top #(
  parameter int MAX_WIDTH = rgb2yuv_pkg::MaxWidthDef
) (
  input  logic                             clk,
  input  logic                             rst_n,

  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic [7:0]                       in_red,
  input  logic [7:0]                       in_green,
  input  logic [7:0]                       in_blue,

  output logic                             out_valid,
  input  logic                             out_stall,
  output logic [7:0]                       out_luma,
  output logic                             out_chroma_valid,
  output logic [7:0]                       out_blue_difference,
  output logic [7:0]                       out_red_difference,

  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [rgb2yuv_pkg::CfgIdxW-1:0]  cfg_index,
  input  logic [rgb2yuv_pkg::CfgDataW-1:0] cfg_data
);

  localparam int LineDepth = (MAX_WIDTH + 1) / 2;
  localparam int AddrW     = (LineDepth > 1) ? $clog2(LineDepth) : 1;
  localparam int ItemW     = $bits(rgb2yuv_pkg::rgb2yuv_item_t);
  localparam int QDataW    = ItemW + AddrW;

  rgb2yuv_pkg::rgb2yuv_item_t front_item;
  rgb2yuv_pkg::rgb2yuv_item_t back_item;
  logic [AddrW-1:0]           front_addr;
  logic [QDataW-1:0]          q_out;
  logic                       q_full, q_not_empty, q_pop;
  logic                       pix_accept;

  assign cfg_ready  = 1'b1;
  assign in_stall   = q_full;
  assign pix_accept = in_valid && !q_full;

  rgb2yuv_front #(
    .MAX_WIDTH (MAX_WIDTH),
    .AddrW     (AddrW)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_valid && cfg_ready),
    .cfg_idx    (cfg_index),
    .cfg_wdata  (cfg_data),
    .pix_accept (pix_accept),
    .pix_red    (in_red),
    .pix_green  (in_green),
    .pix_blue   (in_blue),
    .item       (front_item),
    .item_addr  (front_addr)
  );

  rgb2yuv_queue #(
    .DataW (QDataW),
    .Depth (rgb2yuv_pkg::QueueDepth)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (pix_accept),
    .push_data ({front_addr, front_item}),
    .full      (q_full),
    .pop       (q_pop),
    .not_empty (q_not_empty),
    .pop_data  (q_out)
  );

  assign back_item = rgb2yuv_pkg::rgb2yuv_item_t'(q_out[ItemW-1:0]);

  rgb2yuv_back #(
    .LineDepth (LineDepth),
    .AddrW     (AddrW)
  ) u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .q_valid          (q_not_empty),
    .q_item           (back_item),
    .q_addr           (q_out[QDataW-1:ItemW]),
    .q_pop            (q_pop),
    .res_valid        (out_valid),
    .res_stall        (out_stall),
    .res_luma         (out_luma),
    .res_chroma_valid (out_chroma_valid),
    .res_cb           (out_blue_difference),
    .res_cr           (out_red_difference)
  );

endmodule

/* test/tb.sv */
`timescale 1ns / 100ps

module tb;

  // Cycles to let pass after the last result before touching the size registers:
  // margin for the pipeline and the front-end queue.
  localparam int SettleCycles = 10;
  localparam int RandomPixels = 950;

  typedef struct packed {
    logic [7:0] luma;
    logic       chroma_valid;
    logic [7:0] cb;
    logic [7:0] cr;
  } yuv_result_t;

  logic                             clk;
  logic                             rst_n;
  logic                             in_valid;
  logic                             in_stall;
  logic [7:0]                       in_red;
  logic [7:0]                       in_green;
  logic [7:0]                       in_blue;
  logic                             out_valid;
  logic                             out_stall;
  logic [7:0]                       out_luma;
  logic                             out_chroma_valid;
  logic [7:0]                       out_blue_difference;
  logic [7:0]                       out_red_difference;
  logic                             cfg_valid;
  logic                             cfg_ready;
  logic [rgb2yuv_pkg::CfgIdxW-1:0]  cfg_index;
  logic [rgb2yuv_pkg::CfgDataW-1:0] cfg_data;

  rgb_to_yuv420_converter_top u_dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_red              (in_red),
    .in_green            (in_green),
    .in_blue             (in_blue),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_luma            (out_luma),
    .out_chroma_valid    (out_chroma_valid),
    .out_blue_difference (out_blue_difference),
    .out_red_difference  (out_red_difference),
    .cfg_valid           (cfg_valid),
    .cfg_ready           (cfg_ready),
    .cfg_index           (cfg_index),
    .cfg_data            (cfg_data)
  );

  // Converter state as this bench sees it: size registers, raster position,
  // the even row's pair sums and the previous pixel of the row.
  logic [rgb2yuv_pkg::CfgDataW-1:0] width_reg =
    rgb2yuv_pkg::CfgDataW'(rgb2yuv_pkg::WidthReset);
  logic [rgb2yuv_pkg::CfgDataW-1:0] height_reg =
    rgb2yuv_pkg::CfgDataW'(rgb2yuv_pkg::HeightReset);
  int unsigned         col_pos = 0;
  int unsigned         row_pos = 0;
  logic [26:0]         pair_line [0:rgb2yuv_pkg::MaxWidthDef/2-1];
  logic [23:0]         left_hold = '0;

  // Results still owed by the converter, oldest first
  yuv_result_t yuv_expect [$];

  // Idling and hold-off controls shared by the sender, the sink and the tests
  bit in_idle_en = 1'b1;
  bit out_idle_en = 1'b1;
  int hold_off_cycles = 0;

  int fail_count = 0;
  int pixels_sent = 0;
  int random_pixels = 0;
  int blocks_checked = 0;
  int reg_writes = 0;
  int in_stall_cycles = 0;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Give up on a hung run well past the slowest legal one
  initial begin
    #2_000_000;
    $display("rgb_to_yuv420_converter_top regression: fail");
    $finish;
  end

  function automatic logic [7:0] clamp_byte(input int v);
    if (v < 0) return 8'd0;
    if (v > 255) return 8'd255;
    return v[7:0];
  endfunction

  // Chroma from a weighted sum: round, floor shift, bias, clamp
  function automatic logic [7:0] chroma_level(input int t);
    return clamp_byte(((t + 128) >>> 8) + 128);
  endfunction

  function automatic int unsigned eff_width();
    if (width_reg == 0) return 1;
    if (width_reg > rgb2yuv_pkg::MaxWidthDef) return rgb2yuv_pkg::MaxWidthDef;
    return 32'(width_reg);
  endfunction

  function automatic int unsigned eff_height();
    if (height_reg == 0) return 1;
    if (height_reg > rgb2yuv_pkg::HeightLimit) return rgb2yuv_pkg::HeightLimit;
    return 32'(height_reg);
  endfunction

  // Work out the result of one accepted pixel and advance the raster position
  task automatic predict_pixel(input logic [7:0] r, input logic [7:0] g, input logic [7:0] b);
    int unsigned sr, sg, sb, cnt, sh, idx;
    int          ar, ag, ab;
    bit          odd_col, odd_row, last_col, last_row, closes;
    logic [26:0] pair;
    yuv_result_t res;
    odd_col = col_pos[0];
    odd_row = row_pos[0];
    last_col = (col_pos + 1 >= eff_width());
    last_row = (row_pos + 1 >= eff_height());
    idx = col_pos >> 1;
    sr = 32'(r);
    sg = 32'(g);
    sb = 32'(b);
    cnt = 1;
    closes = 1'b0;
    if (odd_col) begin
      sr += 32'(left_hold[7:0]);
      sg += 32'(left_hold[15:8]);
      sb += 32'(left_hold[23:16]);
      cnt = 2;
    end
    if (odd_col || last_col) begin
      if (!odd_row) begin
        pair_line[idx] = {sb[8:0], sg[8:0], sr[8:0]};
        closes = last_row;
      end else begin
        pair = pair_line[idx];
        sr += 32'(pair[8:0]);
        sg += 32'(pair[17:9]);
        sb += 32'(pair[26:18]);
        cnt = cnt * 2;
        closes = 1'b1;
      end
    end
    res.luma = clamp_byte(((66 * int'(r) + 129 * int'(g) + 25 * int'(b) + 128) >> 8) + 16);
    res.chroma_valid = closes;
    res.cb = 8'd0;
    res.cr = 8'd0;
    if (closes) begin
      sh = (cnt == 4) ? 2 : ((cnt == 2) ? 1 : 0);
      ar = sr >> sh;
      ag = sg >> sh;
      ab = sb >> sh;
      res.cb = chroma_level(-38 * ar - 74 * ag + 112 * ab);
      res.cr = chroma_level(112 * ar - 94 * ag - 18 * ab);
    end
    left_hold = {b, g, r};
    if (last_col) begin
      col_pos = 0;
      row_pos = last_row ? 0 : row_pos + 1;
    end else begin
      col_pos = col_pos + 1;
    end
    yuv_expect.push_back(res);
  endtask

  // Offer one pixel after a random gap; hold it until the converter takes it
  task automatic send_pixel(input logic [7:0] r, input logic [7:0] g, input logic [7:0] b);
    int gap;
    gap = in_idle_en ? $urandom_range(0, 12) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_red <= r;
    in_green <= g;
    in_blue <= b;
    @(posedge clk);
    while (in_stall) begin
      in_stall_cycles++;
      @(posedge clk);
    end
    predict_pixel(r, g, b);
    pixels_sent++;
  endtask

  // Drop the input, wait for every owed result, then let the pipeline settle
  task automatic drain();
    int waited;
    waited = 0;
    in_valid <= 1'b0;
    while (yuv_expect.size() != 0 && waited < 20000) begin
      @(posedge clk);
      waited++;
    end
    repeat (SettleCycles) @(posedge clk);
  endtask

  // Write one size register; a write also sends the raster back to the frame start
  task automatic write_reg(input logic [rgb2yuv_pkg::CfgIdxW-1:0] idx,
                           input logic [rgb2yuv_pkg::CfgDataW-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    if (idx == rgb2yuv_pkg::RegImageWidth) begin
      width_reg = val;
    end else begin
      height_reg = val;
    end
    col_pos = 0;
    row_pos = 0;
    reg_writes++;
    @(posedge clk);
  endtask

  task automatic set_frame(input int w, input int h);
    drain();
    write_reg(rgb2yuv_pkg::RegImageWidth, rgb2yuv_pkg::CfgDataW'(w));
    write_reg(rgb2yuv_pkg::RegImageHeight, rgb2yuv_pkg::CfgDataW'(h));
  endtask

  // Channel level biased towards the rails
  function automatic logic [7:0] rand_level();
    case ($urandom_range(0, 9))
      0: return 8'd0;
      1: return 8'd255;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  task automatic send_random_pixel();
    send_pixel(rand_level(), rand_level(), rand_level());
  endtask

  // Luma only: the reset size of 640 by 480 closes no block in row 0
  task automatic test_reset_size();
    send_pixel(8'd0, 8'd0, 8'd0);
    send_pixel(8'd255, 8'd255, 8'd255);
  endtask

  // Full blocks of rail colours, then a wrap into the next frame
  task automatic test_colour_extremes();
    set_frame(2, 2);
    send_pixel(8'd0, 8'd0, 8'd0);
    send_pixel(8'd255, 8'd255, 8'd255);
    send_pixel(8'd255, 8'd0, 8'd0);
    send_pixel(8'd0, 8'd0, 8'd255);
    send_pixel(8'd0, 8'd255, 8'd0);
    send_pixel(8'd255, 8'd255, 8'd255);
    send_pixel(8'd0, 8'd255, 8'd255);
    send_pixel(8'd255, 8'd0, 8'd255);
  endtask

  // Zero sizes act as one: every pixel is a block of its own
  task automatic test_zero_size();
    set_frame(0, 0);
    repeat (3) send_random_pixel();
  endtask

  // Odd width and height give blocks of one and two pixels; run past the wrap
  task automatic test_partial_blocks();
    set_frame(3, 3);
    repeat (10) send_random_pixel();
  endtask

  // Sizes beyond the limits clamp rather than truncate
  task automatic test_oversize();
    set_frame(4097, 1);
    repeat (3) send_random_pixel();
    set_frame(1, 4097);
    repeat (3) send_random_pixel();
  endtask

  // Start of a row at the clamped maximum width, flat out on both sides
  task automatic test_widest_row();
    set_frame(8191, 1);
    in_idle_en = 1'b0;
    out_idle_en = 1'b0;
    repeat (60) send_random_pixel();
    in_idle_en = 1'b1;
    out_idle_en = 1'b1;
  endtask

  // Hold the result side off for a long stretch while pixels keep coming
  task automatic test_backpressure();
    set_frame(5, 4);
    in_idle_en = 1'b0;
    hold_off_cycles = 80;
    repeat (60) send_random_pixel();
    in_idle_en = 1'b1;
  endtask

  // Random frame sizes, whole frames mostly, some cut short by the next write
  task automatic test_random_frames();
    int w, h, n, pick, frame_px;
    while (random_pixels < RandomPixels) begin
      drain();
      in_idle_en = ($urandom_range(0, 3) != 0);
      out_idle_en = ($urandom_range(0, 3) != 0);
      pick = $urandom_range(0, 19);
      if (pick < 14) begin
        w = $urandom_range(1, 10);
      end else if (pick < 18) begin
        w = $urandom_range(11, 64);
      end else if (pick == 18) begin
        w = 0;
      end else begin
        w = $urandom_range(4090, 8191);
      end
      pick = $urandom_range(0, 19);
      if (pick < 16) begin
        h = $urandom_range(1, 8);
      end else if (pick < 18) begin
        h = $urandom_range(9, 24);
      end else if (pick == 18) begin
        h = 0;
      end else begin
        h = $urandom_range(4090, 8191);
      end
      case ($urandom_range(0, 3))
        0: write_reg(rgb2yuv_pkg::RegImageWidth, rgb2yuv_pkg::CfgDataW'(w));
        1: write_reg(rgb2yuv_pkg::RegImageHeight, rgb2yuv_pkg::CfgDataW'(h));
        2: begin
          write_reg(rgb2yuv_pkg::RegImageHeight, rgb2yuv_pkg::CfgDataW'(h));
          write_reg(rgb2yuv_pkg::RegImageWidth, rgb2yuv_pkg::CfgDataW'(w));
        end
        default: begin
          write_reg(rgb2yuv_pkg::RegImageWidth, rgb2yuv_pkg::CfgDataW'(w));
          write_reg(rgb2yuv_pkg::RegImageHeight, rgb2yuv_pkg::CfgDataW'(h));
        end
      endcase
      frame_px = eff_width() * eff_height();
      if (frame_px <= 120) begin
        n = frame_px * $urandom_range(1, 2);
        if ($urandom_range(0, 3) == 0) n += $urandom_range(1, eff_width());
      end else begin
        n = $urandom_range(20, 150);
      end
      repeat (n) begin
        send_random_pixel();
        random_pixels++;
      end
    end
  endtask

  // Result sink: stall for a random spell before each result, or for the
  // long hold-off when a test asks for one
  initial begin : result_sink
    int stall_len;
    out_stall = 1'b0;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      if (hold_off_cycles > 0) begin
        stall_len = hold_off_cycles;
        hold_off_cycles = 0;
      end else begin
        stall_len = out_idle_en ? $urandom_range(0, 12) : 0;
      end
      if (stall_len > 0) begin
        out_stall <= 1'b1;
        repeat (stall_len) @(posedge clk);
        out_stall <= 1'b0;
      end
      @(posedge clk);
      while (!out_valid) @(posedge clk);
    end
  end

  task automatic note_fail(input string msg);
    fail_count++;
    if (fail_count <= 10) $display("%t: %s", $realtime, msg);
  endtask

  // Compare each result taken with the oldest one owed
  always @(posedge clk) begin : result_check
    yuv_result_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (yuv_expect.size() == 0) begin
        note_fail($sformatf("result with nothing owed: luma %0d chroma_valid %0b",
                            out_luma, out_chroma_valid));
      end else begin
        want = yuv_expect.pop_front();
        if (want.chroma_valid) blocks_checked++;
        if (out_luma !== want.luma || out_chroma_valid !== want.chroma_valid ||
            out_blue_difference !== want.cb || out_red_difference !== want.cr) begin
          note_fail($sformatf(
            "mismatch luma %0d/%0d chroma_valid %0b/%0b cb %0d/%0d cr %0d/%0d (exp/got)",
            want.luma, out_luma, want.chroma_valid, out_chroma_valid,
            want.cb, out_blue_difference, want.cr, out_red_difference));
        end
      end
    end
  end

  initial begin
    // Hold every input at a known value from time zero
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_red = '0;
    in_green = '0;
    in_blue = '0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    for (int k = 0; k < rgb2yuv_pkg::MaxWidthDef / 2; k++) pair_line[k] = '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_size();
    test_colour_extremes();
    test_zero_size();
    test_partial_blocks();
    test_oversize();
    test_widest_row();
    test_backpressure();
    test_random_frames();
    drain();

    // Anything still owed never arrived
    if (yuv_expect.size() != 0) begin
      note_fail($sformatf("%0d results never arrived", yuv_expect.size()));
    end
    $display("covered %0d pixels (%0d random) and %0d chroma blocks over %0d size writes",
             pixels_sent, random_pixels, blocks_checked, reg_writes);
    $display("input held off for %0d cycles; %0d failures", in_stall_cycles, fail_count);
    if (fail_count == 0) begin
      $display("rgb_to_yuv420_converter_top regression: pass");
    end else begin
      $display("rgb_to_yuv420_converter_top regression: fail");
    end
    $finish;
  end

endmodule

/* rgb_to_yuv420_converter_top.f */
rtl/rgb2yuv_pkg.sv
rtl/rgb2yuv_queue.sv
rtl/rgb2yuv_front.sv
rtl/rgb2yuv_back.sv
rtl/rgb_to_yuv420_converter_top.sv
test/tb.sv
